### rtl/biu_pkg.sv
package biu_pkg;

  // Item kinds carried on in_tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;

  // Field widths.
  localparam int COORD_W  = 11;
  localparam int PIX_W    = 8;
  localparam int FACTOR_W = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  // Shared serial divider: a 12-bit dividend covers both an 11-bit coordinate
  // and a blend numerator of at most 255 * 15.
  localparam int DIV_W   = 12;
  localparam int DIV_CNT_W = 4;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [FACTOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_W-1:0]    quotient;
    logic [FACTOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

### rtl/biu_divider.sv
module biu_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  biu_pkg::div_req_t req,
  output biu_pkg::div_rsp_t rsp
);

  logic [biu_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [biu_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [biu_pkg::FACTOR_W-1:0]  rem_r, rem_nxt;
  logic [biu_pkg::FACTOR_W-1:0]  div_r, div_nxt;
  logic                          done_r, done_nxt;
  logic [biu_pkg::FACTOR_W:0]    trial;
  logic                          fits;

  // Restoring division, one quotient bit per cycle. The dividend shifts out of
  // the top of quo_r while the quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[biu_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = biu_pkg::DIV_CNT_W'(biu_pkg::DIV_W);
      quo_nxt = req.dividend;
      rem_nxt = '0;
      div_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      quo_nxt  = {quo_r[biu_pkg::DIV_W-2:0], fits};
      rem_nxt  = fits ? biu_pkg::FACTOR_W'(trial - {1'b0, div_r})
                      : biu_pkg::FACTOR_W'(trial);
      done_nxt = (cnt_r == biu_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

### rtl/biu_frame_ram.sv
module biu_frame_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [biu_pkg::PIX_W-1:0] wdata,
  output logic [biu_pkg::PIX_W-1:0] rdata
);

  logic [biu_pkg::PIX_W-1:0] mem [DEPTH];
  logic [biu_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/bilinear_image_upscaler.sv
// Bilinear integer upscaler with an on-chip source frame.
//
// Input words arrive on in_*. in_tuser selects the kind: a write stores in_tdata
// pixel_in at source column coord_x, row coord_y inside the frame and gives no result;
// a read names a pixel of the frame upscaled by scale_factor and gives one
// result word on out_*: the bilinear blend of its four source neighbors, or
// zero with range_error set when the coordinate lies outside the frame.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must write it only while no word is in flight; the block does not enforce it.
//
// One word is processed at a time. A read outside the frame goes straight to
// the output; any other read uses the shared serial divider, which splits both
// coordinates and normalizes each of up to three blends whose fraction is
// nonzero, plus four reads of the single-port frame memory.
// The result sits in an output register: a new word is taken while it waits,
// and a finished read holds until out_tready frees the register.
// Reset restores 256 x 256 pixels with factor 2 and empties the output; the
// frame memory is not cleared and a pixel must be written before it is read.
module bilinear_image_upscaler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_FACTOR = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // coord_x [10:0], coord_y [21:11], pixel_in [29:22], zero [31:30]
  input  logic [biu_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_out [7:0]
  output logic [biu_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // range_error [0]
  output logic                              out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [biu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [biu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EXT_W = 12;
  localparam int PW    = 16;
  localparam int FW    = biu_pkg::FACTOR_W;
  localparam int XW    = biu_pkg::COORD_W;
  localparam int PXW   = biu_pkg::PIX_W;

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_CHECK, S_DIV_X, S_DIV_Y,
    S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_RD_W,
    S_BL1, S_BL1_W, S_BL2, S_BL2_W, S_BL3, S_BL3_W, S_OUT
  } state_t;

  // Configuration and the clamped values derived from it.
  logic [biu_pkg::CFG_DATA_W-1:0] sw_r, sh_r;
  logic [FW-1:0]                  sf_r;
  logic [EXT_W-1:0]               w_ext, h_ext;
  logic [FW-1:0]                  n_val;
  logic [CW-1:0]                  wlast_r;
  logic [RW-1:0]                  hlast_r;
  logic [PW-1:0]                  wn_r, hn_r;
  logic [FW-1:0]                  n_r;

  always_comb begin
    w_ext = {3'b000, sw_r};
    if (w_ext == '0) begin
      w_ext = EXT_W'(1);
    end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
      w_ext = EXT_W'(MAX_WIDTH);
    end
    h_ext = {3'b000, sh_r};
    if (h_ext == '0) begin
      h_ext = EXT_W'(1);
    end else if (h_ext > EXT_W'(MAX_HEIGHT)) begin
      h_ext = EXT_W'(MAX_HEIGHT);
    end
    n_val = sf_r;
    if (sf_r == '0) begin
      n_val = FW'(1);
    end else if ({1'b0, sf_r} > (FW + 1)'(MAX_FACTOR)) begin
      n_val = FW'(MAX_FACTOR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= biu_pkg::CFG_DATA_W'(256);
      sh_r    <= biu_pkg::CFG_DATA_W'(256);
      sf_r    <= FW'(2);
      wlast_r <= '0;
      hlast_r <= '0;
      wn_r    <= '0;
      hn_r    <= '0;
      n_r     <= FW'(1);
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          biu_pkg::CFG_SRC_WIDTH:    sw_r <= cfg_wdata;
          biu_pkg::CFG_SRC_HEIGHT:   sh_r <= cfg_wdata;
          biu_pkg::CFG_SCALE_FACTOR: sf_r <= cfg_wdata[FW-1:0];
          default: ;
        endcase
      end
      wlast_r <= CW'(w_ext - 1'b1);
      hlast_r <= RW'(h_ext - 1'b1);
      wn_r    <= PW'(w_ext) * PW'(n_val);
      hn_r    <= PW'(h_ext) * PW'(n_val);
      n_r     <= n_val;
    end
  end

  // Sequencer registers.
  state_t            state_r, state_nxt;
  logic [XW-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic [PXW-1:0]    pix_r, pix_nxt;
  logic [CW-1:0]     sx_r, sx_nxt;
  logic [RW-1:0]     sy_r, sy_nxt;
  logic [FW-1:0]     fx_r, fx_nxt, fy_r, fy_nxt;
  logic [PXW-1:0]    a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [PXW-1:0]    p1_r, p1_nxt, p2_r, p2_nxt;
  logic [PXW-1:0]    res_r, res_nxt;
  logic              err_r, err_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [PXW-1:0]    out_pix_r, out_pix_nxt;
  logic              out_err_r, out_err_nxt;

  biu_pkg::div_req_t div_req;
  biu_pkg::div_rsp_t div_rsp;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PXW-1:0]    ram_rdata;

  logic [CW-1:0]     sx1;
  logic [RW-1:0]     sy1;
  logic              wr_in_range;
  logic              rd_out_range;
  logic [PXW-1:0]    bl_lo, bl_hi;
  logic [FW-1:0]     bl_r;
  logic [biu_pkg::DIV_W-1:0] bl_num;
  logic              out_free;

  function automatic logic [AW-1:0] pix_addr(input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
    return AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  assign sx1 = (sx_r < wlast_r) ? CW'(sx_r + 1'b1) : wlast_r;
  assign sy1 = (sy_r < hlast_r) ? RW'(sy_r + 1'b1) : hlast_r;

  assign wr_in_range  = (x_r <= XW'(wlast_r)) && (y_r <= XW'(hlast_r));
  assign rd_out_range = (PW'(x_r) >= wn_r) || (PW'(y_r) >= hn_r);

  assign out_free = !out_tvalid_r || out_tready;

  // Operands of the blend in progress: lo*(n-r) + hi*r never goes negative.
  always_comb begin
    bl_lo = a_r;
    bl_hi = b_r;
    bl_r  = fx_r;
    case (state_r)
      S_BL2, S_BL2_W: begin
        bl_lo = c_r;
        bl_hi = d_r;
      end
      S_BL3, S_BL3_W: begin
        bl_lo = p1_r;
        bl_hi = p2_r;
        bl_r  = fy_r;
      end
      default: ;
    endcase
    bl_num = biu_pkg::DIV_W'(bl_lo) * biu_pkg::DIV_W'(FW'(n_r - bl_r))
           + biu_pkg::DIV_W'(bl_hi) * biu_pkg::DIV_W'(bl_r);
  end

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    pix_nxt        = pix_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    fx_nxt         = fx_r;
    fy_nxt         = fy_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    res_nxt        = res_r;
    err_nxt        = err_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_pix_nxt    = out_pix_r;
    out_err_nxt    = out_err_r;
    div_req.start    = 1'b0;
    div_req.dividend = bl_num;
    div_req.divisor  = n_r;
    ram_we   = 1'b0;
    ram_addr = pix_addr(sy_r, sx_r);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = in_tdata[10:0];
          y_nxt     = in_tdata[21:11];
          pix_nxt   = in_tdata[29:22];
          state_nxt = (in_tuser == biu_pkg::FUNC_WRITE) ? S_WRITE : S_CHECK;
        end
      end
      S_WRITE: begin
        ram_addr  = pix_addr(RW'(y_r), CW'(x_r));
        ram_we    = wr_in_range;
        state_nxt = S_IDLE;
      end
      S_CHECK: begin
        if (rd_out_range) begin
          res_nxt   = '0;
          err_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          err_nxt          = 1'b0;
          div_req.start    = 1'b1;
          div_req.dividend = biu_pkg::DIV_W'(x_r);
          state_nxt        = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (div_rsp.done) begin
          sx_nxt           = CW'(div_rsp.quotient);
          fx_nxt           = div_rsp.remainder;
          div_req.start    = 1'b1;
          div_req.dividend = biu_pkg::DIV_W'(y_r);
          state_nxt        = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_rsp.done) begin
          sy_nxt    = RW'(div_rsp.quotient);
          fy_nxt    = div_rsp.remainder;
          state_nxt = S_RD_A;
        end
      end
      // Memory reads are issued one per cycle; each result is registered and arrives in the next cycle.
      S_RD_A: begin
        ram_addr  = pix_addr(sy_r, sx_r);
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        ram_addr  = pix_addr(sy_r, sx1);
        a_nxt     = ram_rdata;
        state_nxt = S_RD_C;
      end
      S_RD_C: begin
        ram_addr  = pix_addr(sy1, sx_r);
        b_nxt     = ram_rdata;
        state_nxt = S_RD_D;
      end
      S_RD_D: begin
        ram_addr  = pix_addr(sy1, sx1);
        c_nxt     = ram_rdata;
        state_nxt = S_RD_W;
      end
      S_RD_W: begin
        d_nxt     = ram_rdata;
        state_nxt = S_BL1;
      end
      // A blend with a zero fraction is the lower neighbor itself.
      S_BL1: begin
        if (fx_r == '0) begin
          p1_nxt    = a_r;
          state_nxt = S_BL2;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_BL1_W;
        end
      end
      S_BL1_W: begin
        if (div_rsp.done) begin
          p1_nxt    = PXW'(div_rsp.quotient);
          state_nxt = S_BL2;
        end
      end
      S_BL2: begin
        if (fx_r == '0) begin
          p2_nxt    = c_r;
          state_nxt = S_BL3;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_BL2_W;
        end
      end
      S_BL2_W: begin
        if (div_rsp.done) begin
          p2_nxt    = PXW'(div_rsp.quotient);
          state_nxt = S_BL3;
        end
      end
      S_BL3: begin
        if (fy_r == '0) begin
          res_nxt   = p1_r;
          state_nxt = S_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_BL3_W;
        end
      end
      S_BL3_W: begin
        if (div_rsp.done) begin
          res_nxt   = PXW'(div_rsp.quotient);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_pix_nxt    = res_r;
          out_err_nxt    = err_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    pix_r     <= pix_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    fx_r      <= fx_nxt;
    fy_r      <= fy_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    d_r       <= d_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
    out_pix_r <= out_pix_nxt;
    out_err_r <= out_err_nxt;
  end

  biu_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  biu_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pix_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_err_r;

endmodule

### rtl/biu_checker.sv
module biu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [biu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word present after reset");

  // An out-of-frame read always reports a zero pixel.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("range error with nonzero pixel");

  // One word is processed at a time, so the input closes after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

endmodule

bind bilinear_image_upscaler biu_checker u_biu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/tb_bilinear_image_upscaler.sv
`timescale 1ns / 1ps

module tb_bilinear_image_upscaler;

  localparam int MAX_W    = 256;
  localparam int MAX_H    = 256;
  localparam int MAX_N    = 8;
  localparam int IDLE_GAP = 100;

  typedef struct packed {
    logic                        func;
    logic [biu_pkg::COORD_W-1:0] x;
    logic [biu_pkg::COORD_W-1:0] y;
    logic [biu_pkg::PIX_W-1:0]   pix;
  } pixel_word_t;

  typedef struct packed {
    logic [biu_pkg::PIX_W-1:0] pix;
    logic                      err;
  } upscaled_pix_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [biu_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [biu_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [biu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [biu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bilinear_image_upscaler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pixel_word_t   pending_words[$];
  upscaled_pix_t expected_pix_q[$];

  // Register values as written; the block clamps them on use.
  int src_w_reg  = 256;
  int src_h_reg  = 256;
  int factor_reg = 2;

  bit [biu_pkg::PIX_W-1:0] frame_model [0:MAX_W*MAX_H-1];
  bit                      gen_written [0:MAX_W*MAX_H-1];

  bit quiet = 1'b0;
  int fail_count = 0;
  int n_writes = 0, n_reads = 0, n_range_err = 0, n_blended = 0, n_checked = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_dim(int raw, int maxv);
    if (raw == 0) return 1;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  function automatic int lerp(int lo, int hi, int r, int n);
    return (lo * n + r * (hi - lo)) / n;
  endfunction

  function automatic upscaled_pix_t upscale_at(int x, int y);
    upscaled_pix_t res;
    int w, h, n, sx, sy, fx, fy, sx1, sy1, p1, p2;
    w = eff_dim(src_w_reg, MAX_W);
    h = eff_dim(src_h_reg, MAX_H);
    n = eff_dim(factor_reg, MAX_N);
    res.pix = '0;
    res.err = 1'b0;
    if (x >= w * n || y >= h * n) begin
      res.err = 1'b1;
      return res;
    end
    sx = x / n;
    fx = x % n;
    sy = y / n;
    fy = y % n;
    sx1 = (sx + 1 < w) ? sx + 1 : w - 1;
    sy1 = (sy + 1 < h) ? sy + 1 : h - 1;
    if (fx == 0 && fy == 0) begin
      res.pix = frame_model[sy*MAX_W+sx];
    end else begin
      p1 = lerp(frame_model[sy*MAX_W+sx], frame_model[sy*MAX_W+sx1], fx, n);
      p2 = lerp(frame_model[sy1*MAX_W+sx], frame_model[sy1*MAX_W+sx1], fx, n);
      res.pix = biu_pkg::PIX_W'(lerp(p1, p2, fy, n));
    end
    return res;
  endfunction

  // A read must only touch source pixels that were written earlier.
  function automatic bit read_safe(int x, int y);
    int w, h, n, sx, sy, sx1, sy1;
    w = eff_dim(src_w_reg, MAX_W);
    h = eff_dim(src_h_reg, MAX_H);
    n = eff_dim(factor_reg, MAX_N);
    if (x >= w * n || y >= h * n) return 1'b1;
    sx = x / n;
    sy = y / n;
    sx1 = (sx + 1 < w) ? sx + 1 : w - 1;
    sy1 = (sy + 1 < h) ? sy + 1 : h - 1;
    if (!gen_written[sy*MAX_W+sx]) return 1'b0;
    if (x % n == 0 && y % n == 0) return 1'b1;
    return gen_written[sy*MAX_W+sx1] && gen_written[sy1*MAX_W+sx] &&
           gen_written[sy1*MAX_W+sx1];
  endfunction

  function automatic int pick_pixel();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(255);
  endfunction

  task automatic push_write(int x, int y, int pix);
    pixel_word_t wd;
    wd.func = biu_pkg::FUNC_WRITE;
    wd.x = biu_pkg::COORD_W'(x);
    wd.y = biu_pkg::COORD_W'(y);
    wd.pix = biu_pkg::PIX_W'(pix);
    if (x < eff_dim(src_w_reg, MAX_W) && y < eff_dim(src_h_reg, MAX_H))
      gen_written[y*MAX_W+x] = 1'b1;
    pending_words.push_back(wd);
  endtask

  task automatic push_read(int x, int y);
    pixel_word_t wd;
    wd.func = biu_pkg::FUNC_READ;
    wd.x = biu_pkg::COORD_W'(x);
    wd.y = biu_pkg::COORD_W'(y);
    wd.pix = biu_pkg::PIX_W'($urandom_range(255));
    pending_words.push_back(wd);
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_tvalid || expected_pix_q.size() != 0)
      @(posedge clk);
    // A write gives no result, so let the block drain whatever it still holds.
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(logic [biu_pkg::CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= biu_pkg::CFG_DATA_W'(value);
    if (idx == biu_pkg::CFG_SRC_WIDTH) src_w_reg = value & 'h1FF;
    else if (idx == biu_pkg::CFG_SRC_HEIGHT) src_h_reg = value & 'h1FF;
    else if (idx == biu_pkg::CFG_SCALE_FACTOR) factor_reg = value & 'hF;
  endtask

  task automatic run_phase(int rw, int rh, int rn, bit fill, int n_items);
    int w, h, n, lim_x, lim_y, x, y, k, r, tries;
    wait_idle();
    write_reg(biu_pkg::CFG_SRC_WIDTH, rw);
    write_reg(biu_pkg::CFG_SRC_HEIGHT, rh);
    write_reg(biu_pkg::CFG_SCALE_FACTOR, rn);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    w = eff_dim(src_w_reg, MAX_W);
    h = eff_dim(src_h_reg, MAX_H);
    n = eff_dim(factor_reg, MAX_N);
    lim_x = w * n;
    lim_y = h * n;
    if (fill)
      for (y = 0; y < h; y++)
        for (x = 0; x < w; x++)
          push_write(x, y, pick_pixel());
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // Mostly lands outside the source frame and is dropped.
        push_write($urandom_range(2047), $urandom_range(2047), pick_pixel());
      end else if (r < 16) begin
        push_write($urandom_range(w - 1), $urandom_range(h - 1), pick_pixel());
      end else if (r < 26 && (lim_x < 2048 || lim_y < 2048)) begin
        if (lim_x < 2048 && ($urandom_range(1) == 1 || lim_y >= 2048))
          push_read($urandom_range(2047, lim_x), $urandom_range(2047));
        else
          push_read($urandom_range(2047), $urandom_range(2047, lim_y));
      end else begin
        tries = 0;
        do begin
          x = ($urandom_range(3) == 0) ? (($urandom_range(1) == 1) ? lim_x - 1 : 0)
                                        : $urandom_range(lim_x - 1);
          y = ($urandom_range(3) == 0) ? (($urandom_range(1) == 1) ? lim_y - 1 : 0)
                                        : $urandom_range(lim_y - 1);
          tries++;
        end while (!read_safe(x, y) && tries < 16);
        if (read_safe(x, y)) push_read(x, y);
      end
    end
  endtask

  // Driver: holds a word until it is taken, then offers the next one or idles.
  always @(posedge clk) begin : drive_words
    pixel_word_t wd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
        wd = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, wd.pix, wd.y, wd.x};
        in_tuser  <= wd.func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= quiet || ($urandom_range(99) >= 35);
  end

  // Predictor on accepted input words, checker on accepted result words.
  always @(posedge clk) begin : track_and_check
    int x, y;
    upscaled_pix_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        x = int'(in_tdata[biu_pkg::COORD_W-1:0]);
        y = int'(in_tdata[2*biu_pkg::COORD_W-1:biu_pkg::COORD_W]);
        if (in_tuser == biu_pkg::FUNC_WRITE) begin
          n_writes++;
          if (x < eff_dim(src_w_reg, MAX_W) && y < eff_dim(src_h_reg, MAX_H))
            frame_model[y*MAX_W+x] =
              in_tdata[2*biu_pkg::COORD_W+biu_pkg::PIX_W-1:2*biu_pkg::COORD_W];
        end else begin
          n_reads++;
          want = upscale_at(x, y);
          if (want.err) n_range_err++;
          else if (x % eff_dim(factor_reg, MAX_N) != 0 ||
                   y % eff_dim(factor_reg, MAX_N) != 0) n_blended++;
          expected_pix_q.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (expected_pix_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result word pixel=%0d range_error=%0b",
                     out_tdata, out_tuser);
        end else begin
          want = expected_pix_q.pop_front();
          if (out_tdata !== want.pix || out_tuser !== want.err) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"ERROR: result %0d: expected pixel=%0d range_error=%0b, ",
                        "got pixel=%0d range_error=%0b"},
                       n_checked, want.pix, want.err, out_tdata, out_tuser);
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry is 256 x 256 at factor 2: corners, far edge clamping,
    // and reads just past the frame.
    push_write(0, 0, 0);
    push_write(1, 0, 255);
    push_write(0, 1, 255);
    push_write(1, 1, 0);
    push_write(254, 254, 17);
    push_write(255, 254, 200);
    push_write(254, 255, 0);
    push_write(255, 255, 255);
    push_write(256, 0, 99);
    push_write(2047, 2047, 255);
    push_read(0, 0);
    push_read(1, 0);
    push_read(0, 1);
    push_read(1, 1);
    push_read(2, 2);
    push_read(511, 511);
    push_read(510, 510);
    push_read(509, 509);
    push_read(509, 508);
    push_read(512, 0);
    push_read(0, 512);
    push_read(2047, 2047);

    run_phase(4, 3, 3, 1'b1, 150);
    run_phase(1, 1, 1, 1'b1, 30);
    run_phase(256, 1, 8, 1'b1, 120);
    run_phase(1, 256, 8, 1'b1, 120);
    // Zero registers act as one, oversized ones as the maximum.
    run_phase(0, 0, 0, 1'b0, 20);
    run_phase(511, 1, 15, 1'b0, 60);
    quiet = 1'b1;
    run_phase(12, 10, 4, 1'b1, 200);
    wait_idle();
    quiet = 1'b0;
    run_phase(7, 5, 5, 1'b1, 150);
    run_phase(2, 2, 2, 1'b1, 100);
    run_phase(5, 9, 7, 1'b1, 150);
    wait_idle();

    $display("Covered %0d pixel writes and %0d reads over 11 frame geometries.",
             n_writes, n_reads);
    $display("Reads: %0d out of frame, %0d blended, %0d result words checked.",
             n_range_err, n_blended, n_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/biu_pkg.sv
rtl/biu_divider.sv
rtl/biu_frame_ram.sv
rtl/bilinear_image_upscaler.sv
rtl/biu_checker.sv
tb/sv/tb_bilinear_image_upscaler.sv
